// ===== sv/afrp_pkg.sv =====
// shared types and constants for the api frame receive parser
`default_nettype none

package afrp_pkg;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_OK    = 3'd1,
    ST_DELIM = 3'd2,
    ST_TYPE  = 3'd3,
    ST_LONG  = 3'd4,
    ST_SUM   = 3'd5
  } frame_status_t;

  typedef enum logic [0:0] {
    CFG_START_DELIM = 1'b0,
    CFG_FRAME_TYPE  = 1'b1
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 8;

  localparam logic [7:0] START_DELIM_RST = 8'h7E;
  localparam logic [7:0] FRAME_TYPE_RST  = 8'h10;
  localparam logic [7:0] SUM_GOOD        = 8'hFF;
  localparam logic [7:0] COUNT_MAX       = 8'hFF;

  // byte positions within a frame, delimiter at zero
  localparam int POS_LEN_HI   = 1;
  localparam int POS_LEN_LO   = 2;
  localparam int POS_TYPE     = 3;
  localparam int POS_ID       = 4;
  localparam int POS_ADDR_END = 12;
  localparam int POS_SHRT_END = 14;
  localparam int POS_RADIUS   = 15;
  localparam int POS_OPTIONS  = 16;
  localparam int LEN_OFFSET   = 3;
  localparam int DLEN_OFFSET  = 4;

endpackage

`default_nettype wire

// ===== sv/api_frame_receive_parser_core.sv =====
// api frame receive parser: byte stream in, per-byte status and frame fields out
//
//   channel | ports                          | dir | content
//   in      | in_valid in_ready in_rx_byte   | in  | one received byte
//   out     | out_valid out_ready out_*      | out | status, payload byte, frame fields
//   cfg     | cfg_valid cfg_ready cfg_index  | in  | start delimiter, expected type
//           | cfg_data                       |     |
//
// one byte per cycle while the output is not stalled: the frame state is updated and
// the result registered on the accept edge, the result appears the cycle after
// the single output register is refilled in the same cycle it is taken
// a stalled output holds the input off; cfg writes are always taken
// synchronous active-low reset puts the parser in hunting and restores the cfg defaults
`default_nettype none

module api_frame_receive_parser_core
  import afrp_pkg::*;
#(
  parameter int MAX_FRAME_POS = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_rx_byte,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  out_status,
  output logic                        out_payload_valid,
  output logic [7:0]                  out_payload_byte,
  output logic [7:0]                  out_frame_id,
  output logic [63:0]                 out_address_long,
  output logic [15:0]                 out_address_short,
  output logic [7:0]                  out_radius,
  output logic [7:0]                  out_option_bits,
  output logic [7:0]                  out_payload_count,
  output logic [15:0]                 out_data_length,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  // position reaches at most one past the limit before the overrun error
  localparam int PW = $clog2(MAX_FRAME_POS + 2);

  logic [7:0]    start_delim_r;
  logic [7:0]    frame_type_r;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    len_hi_r, len_hi_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [63:0]   addr_l_r, addr_l_nxt;
  logic [15:0]   addr_s_r, addr_s_nxt;
  logic [7:0]    radius_r, radius_nxt;
  logic [7:0]    opts_r, opts_nxt;
  logic [7:0]    pcnt_r, pcnt_nxt;

  logic          ov_r;
  frame_status_t st_r, st_nxt;
  logic          pv_r, pv_nxt;
  logic [7:0]    pb_r, pb_nxt;
  logic [15:0]   dlen_r, dlen_nxt;

  logic          in_fire;
  logic [16:0]   end_pos;

  assign in_ready  = !ov_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign end_pos = {1'b0, len_hi_r, len_lo_r} + 17'(LEN_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= START_DELIM_RST;
      frame_type_r  <= FRAME_TYPE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INDEX_W'(CFG_START_DELIM)) begin
        start_delim_r <= cfg_data;
      end else if (cfg_index == CFG_INDEX_W'(CFG_FRAME_TYPE)) begin
        frame_type_r <= cfg_data;
      end
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    len_hi_nxt = len_hi_r;
    len_lo_nxt = len_lo_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    addr_l_nxt = addr_l_r;
    addr_s_nxt = addr_s_r;
    radius_nxt = radius_r;
    opts_nxt   = opts_r;
    pcnt_nxt   = pcnt_r;
    st_nxt     = ST_BUSY;
    pv_nxt     = 1'b0;
    pb_nxt     = '0;
    dlen_nxt   = '0;

    if (pos_r == '0) begin
      if (in_rx_byte == start_delim_r) begin
        pos_nxt  = PW'(1);
        sum_nxt  = '0;
        pcnt_nxt = '0;
      end
    end else if (in_rx_byte == start_delim_r) begin
      st_nxt  = ST_DELIM;
      pos_nxt = '0;
    end else begin
      // checksum covers the type byte onward
      if (pos_r >= PW'(POS_TYPE)) begin
        sum_nxt = sum_r + in_rx_byte;
      end
      if (pos_r == PW'(POS_LEN_HI)) begin
        len_hi_nxt = in_rx_byte;
        pos_nxt    = pos_r + PW'(1);
      end else if (pos_r == PW'(POS_LEN_LO)) begin
        len_lo_nxt = in_rx_byte;
        pos_nxt    = pos_r + PW'(1);
      end else if (pos_r == PW'(POS_TYPE)) begin
        if (in_rx_byte != frame_type_r) begin
          st_nxt  = ST_TYPE;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end else if (pos_r == PW'(POS_ID)) begin
        id_nxt  = in_rx_byte;
        pos_nxt = pos_r + PW'(1);
      end else if (pos_r <= PW'(POS_ADDR_END)) begin
        addr_l_nxt = {addr_l_r[55:0], in_rx_byte};
        pos_nxt    = pos_r + PW'(1);
      end else if (pos_r <= PW'(POS_SHRT_END)) begin
        addr_s_nxt = {addr_s_r[7:0], in_rx_byte};
        pos_nxt    = pos_r + PW'(1);
      end else if (pos_r == PW'(POS_RADIUS)) begin
        radius_nxt = in_rx_byte;
        pos_nxt    = pos_r + PW'(1);
      end else if (pos_r == PW'(POS_OPTIONS)) begin
        opts_nxt = in_rx_byte;
        pos_nxt  = pos_r + PW'(1);
      end else if (pos_r > PW'(MAX_FRAME_POS)) begin
        st_nxt  = ST_LONG;
        pos_nxt = '0;
      end else if (17'(pos_r) == end_pos) begin
        // checksum byte already folded into sum_nxt
        if (sum_nxt == SUM_GOOD) begin
          st_nxt   = ST_OK;
          dlen_nxt = 16'(pos_r - PW'(DLEN_OFFSET));
        end else begin
          st_nxt = ST_SUM;
        end
        pos_nxt = '0;
      end else begin
        pv_nxt = 1'b1;
        pb_nxt = in_rx_byte;
        if (pcnt_r != COUNT_MAX) begin
          pcnt_nxt = pcnt_r + 8'd1;
        end
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r <= pos_nxt;
        ov_r  <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
      sum_r    <= sum_nxt;
      id_r     <= id_nxt;
      addr_l_r <= addr_l_nxt;
      addr_s_r <= addr_s_nxt;
      radius_r <= radius_nxt;
      opts_r   <= opts_nxt;
      pcnt_r   <= pcnt_nxt;
      st_r     <= st_nxt;
      pv_r     <= pv_nxt;
      pb_r     <= pb_nxt;
      dlen_r   <= dlen_nxt;
    end
  end

  // frame fields show only with a good frame
  always_comb begin
    out_valid         = ov_r;
    out_status        = st_r;
    out_payload_valid = pv_r;
    out_payload_byte  = pb_r;
    out_data_length   = dlen_r;
    if (st_r == ST_OK) begin
      out_frame_id      = id_r;
      out_address_long  = addr_l_r;
      out_address_short = addr_s_r;
      out_radius        = radius_r;
      out_option_bits   = opts_r;
      out_payload_count = pcnt_r;
    end else begin
      out_frame_id      = '0;
      out_address_long  = '0;
      out_address_short = '0;
      out_radius        = '0;
      out_option_bits   = '0;
      out_payload_count = '0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/api_frame_receive_parser_core_test.sv =====
// self-checking testbench for the api frame receive parser core
`timescale 1ns / 1ps

module api_frame_receive_parser_core_test;
  import afrp_pkg::*;

  localparam int MAX_POS     = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES  = 6;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_TYPE,
    FR_MID_DELIM,
    FR_SHORT,
    FR_LONG
  } frame_kind_t;

  typedef struct packed {
    frame_status_t status;
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic [7:0]    frame_id;
    logic [63:0]   address_long;
    logic [15:0]   address_short;
    logic [7:0]    radius;
    logic [7:0]    option_bits;
    logic [7:0]    payload_count;
    logic [15:0]   data_length;
  } parser_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             out_status;
  logic                   out_payload_valid;
  logic [7:0]             out_payload_byte;
  logic [7:0]             out_frame_id;
  logic [63:0]            out_address_long;
  logic [15:0]            out_address_short;
  logic [7:0]             out_radius;
  logic [7:0]             out_option_bits;
  logic [7:0]             out_payload_count;
  logic [15:0]            out_data_length;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = 8'h00;

  // parser state as the predictor sees it
  logic [7:0]  delim_reg = START_DELIM_RST;
  logic [7:0]  type_reg = FRAME_TYPE_RST;
  logic [15:0] rx_pos = '0;
  logic [7:0]  rx_len_hi = '0;
  logic [7:0]  rx_len_lo = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  rx_id = '0;
  logic [63:0] rx_addr_long = '0;
  logic [15:0] rx_addr_short = '0;
  logic [7:0]  rx_radius = '0;
  logic [7:0]  rx_options = '0;
  logic [7:0]  rx_count = '0;

  logic [7:0]  rx_stream[$];
  parser_out_t want_results[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatches = 0;
  int bytes_in = 0;
  int frames_ok = 0;
  int frame_errors = 0;
  int payload_beats = 0;
  int cycles = 0;

  api_frame_receive_parser_core #(
    .MAX_FRAME_POS(MAX_POS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte (out_payload_byte),
    .out_frame_id     (out_frame_id),
    .out_address_long (out_address_long),
    .out_address_short(out_address_short),
    .out_radius       (out_radius),
    .out_option_bits  (out_option_bits),
    .out_payload_count(out_payload_count),
    .out_data_length  (out_data_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic parser_out_t parse_rx_byte(input logic [7:0] b);
    parser_out_t r;
    r = '0;
    r.status = ST_BUSY;
    if (rx_pos == 0) begin
      if (b == delim_reg) begin
        rx_pos = 1;
        rx_sum = '0;
        rx_count = '0;
      end
    end else if (b == delim_reg) begin
      r.status = ST_DELIM;
      rx_pos = 0;
    end else begin
      if (rx_pos >= POS_TYPE) rx_sum = rx_sum + b;
      if (rx_pos == POS_LEN_HI) begin
        rx_len_hi = b;
        rx_pos++;
      end else if (rx_pos == POS_LEN_LO) begin
        rx_len_lo = b;
        rx_pos++;
      end else if (rx_pos == POS_TYPE) begin
        if (b != type_reg) begin
          r.status = ST_TYPE;
          rx_pos = 0;
        end else begin
          rx_pos++;
        end
      end else if (rx_pos == POS_ID) begin
        rx_id = b;
        rx_pos++;
      end else if (rx_pos <= POS_ADDR_END) begin
        rx_addr_long = {rx_addr_long[55:0], b};
        rx_pos++;
      end else if (rx_pos <= POS_SHRT_END) begin
        rx_addr_short = {rx_addr_short[7:0], b};
        rx_pos++;
      end else if (rx_pos == POS_RADIUS) begin
        rx_radius = b;
        rx_pos++;
      end else if (rx_pos == POS_OPTIONS) begin
        rx_options = b;
        rx_pos++;
      end else if (rx_pos > MAX_POS) begin
        // overrun wins over the end-of-frame test
        r.status = ST_LONG;
        rx_pos = 0;
      end else if (int'(rx_pos) == int'({rx_len_hi, rx_len_lo}) + LEN_OFFSET) begin
        if (rx_sum == SUM_GOOD) begin
          r.status = ST_OK;
          r.data_length = 16'(rx_pos - DLEN_OFFSET);
        end else begin
          r.status = ST_SUM;
        end
        rx_pos = 0;
      end else begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        if (rx_count != COUNT_MAX) rx_count++;
        rx_pos++;
      end
    end
    if (r.status == ST_OK) begin
      r.frame_id = rx_id;
      r.address_long = rx_addr_long;
      r.address_short = rx_addr_short;
      r.radius = rx_radius;
      r.option_bits = rx_options;
      r.payload_count = rx_count;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (rx_stream.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // predict on each accepted byte, check each result beat
  always @(posedge clk) begin
    parser_out_t exp_out;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INDEX_W'(CFG_START_DELIM): delim_reg = cfg_data;
          CFG_INDEX_W'(CFG_FRAME_TYPE):  type_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want_results.push_back(parse_rx_byte(in_rx_byte));
        bytes_in++;
      end
      if (out_valid && out_ready) begin
        if (want_results.size() == 0) begin
          $error("result beat with no byte pending, status %0d", out_status);
          mismatches++;
        end else begin
          exp_out = want_results.pop_front();
          check_field("status", exp_out.status, out_status);
          check_field("payload_valid", exp_out.payload_valid, out_payload_valid);
          check_field("payload_byte", exp_out.payload_byte, out_payload_byte);
          check_field("frame_id", exp_out.frame_id, out_frame_id);
          check_field("address_long", exp_out.address_long, out_address_long);
          check_field("address_short", exp_out.address_short, out_address_short);
          check_field("radius", exp_out.radius, out_radius);
          check_field("option_bits", exp_out.option_bits, out_option_bits);
          check_field("payload_count", exp_out.payload_count, out_payload_count);
          check_field("data_length", exp_out.data_length, out_data_length);
          if (exp_out.status == ST_OK) frames_ok++;
          else if (exp_out.status != ST_BUSY) frame_errors++;
          if (exp_out.payload_valid) payload_beats++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] pick_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == a || v == b) v = 8'($urandom);
    return v;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || in_valid || want_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one frame with random content, shaped by kind; returns bytes queued
  task automatic make_frame(input frame_kind_t kind, input logic [7:0] delim,
                            input logic [7:0] ftype, output int nbytes);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] chk;
    int n;
    int len;
    int cut;
    if (kind == FR_SHORT || kind == FR_LONG) n = MAX_POS - POS_OPTIONS + 1;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(13, MAX_POS - POS_OPTIONS - 1);
    else n = $urandom_range(0, 12);
    if (kind == FR_SHORT) len = $urandom_range(0, POS_OPTIONS - LEN_OFFSET);
    else if (kind == FR_LONG) len = $urandom_range(MAX_POS - LEN_OFFSET + 1, 65535);
    else len = n + POS_OPTIONS - LEN_OFFSET + 1;
    do begin
      fb = {};
      fb.push_back(delim);
      fb.push_back(len[15:8]);
      fb.push_back(len[7:0]);
      fb.push_back(ftype);
      repeat (POS_OPTIONS - POS_TYPE + n) fb.push_back(pick_except(delim, delim));
      sum = '0;
      for (int i = POS_TYPE; i < fb.size(); i++) sum = sum + fb[i];
      chk = SUM_GOOD - sum;
      if (kind == FR_BAD_SUM) chk = chk + 8'($urandom_range(1, 255));
    end while (chk == delim && kind != FR_SHORT && kind != FR_LONG);
    if (kind != FR_SHORT && kind != FR_LONG) fb.push_back(chk);
    if (kind == FR_BAD_TYPE) begin
      fb[POS_TYPE] = pick_except(ftype, delim);
      fb = fb[0:POS_TYPE];
    end else if (kind == FR_MID_DELIM) begin
      cut = $urandom_range(1, fb.size() - 1);
      fb[cut] = delim;
      fb = fb[0:cut];
    end
    foreach (fb[i]) rx_stream.push_back(fb[i]);
    nbytes = fb.size();
  endtask

  initial begin
    logic [7:0] dir_frame[$];
    logic [7:0] sum;
    logic [7:0] delim;
    logic [7:0] ftype;
    frame_kind_t kind;
    int got;
    int phase_bytes;
    int pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0, 5: begin
          delim = START_DELIM_RST;
          ftype = FRAME_TYPE_RST;
        end
        1: begin
          delim = 8'hFF;
          ftype = 8'h00;
        end
        2: begin
          // no short frame can open cleanly: the length high byte is the delimiter
          delim = 8'h00;
          ftype = 8'hFF;
        end
        3: begin
          delim = 8'h13;
          ftype = 8'hA5;
        end
        default: begin
          delim = 8'($urandom);
          ftype = pick_except(delim, delim);
        end
      endcase
      write_reg(CFG_START_DELIM, delim);
      write_reg(CFG_FRAME_TYPE, ftype);
      in_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 86 : 0;
      out_stall_pct = (phase < 2) ? 86 : (phase < 4) ? 6 : 0;

      if (phase == 0) begin
        // noise while hunting, a minimal frame with extreme bytes, wrong type,
        // delimiter inside the length field
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        dir_frame = '{START_DELIM_RST, 8'h00, 8'h0E, FRAME_TYPE_RST, 8'hFF,
                      8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h02,
                      8'hFF, 8'h00, 8'h00, 8'hFF};
        sum = '0;
        for (int i = POS_TYPE; i < dir_frame.size(); i++) sum = sum + dir_frame[i];
        dir_frame.push_back(SUM_GOOD - sum);
        foreach (dir_frame[i]) rx_stream.push_back(dir_frame[i]);
        dir_frame = '{START_DELIM_RST, 8'h00, 8'h0E, FRAME_TYPE_RST + 8'h01,
                      START_DELIM_RST, 8'h00, START_DELIM_RST};
        foreach (dir_frame[i]) rx_stream.push_back(dir_frame[i]);
      end

      phase_bytes = 0;
      while (phase_bytes < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) kind = FR_GOOD;
        else if (pick < 68) kind = FR_BAD_SUM;
        else if (pick < 78) kind = FR_BAD_TYPE;
        else if (pick < 92) kind = FR_MID_DELIM;
        else if (pick < 96) kind = FR_SHORT;
        else kind = FR_LONG;
        make_frame(kind, delim, ftype, got);
        phase_bytes += got;
        // line noise between frames, skipped while hunting
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) rx_stream.push_back(pick_except(delim, delim));
      end
      wait_drained();
    end

    if (want_results.size() != 0) begin
      $error("%0d results never arrived", want_results.size());
      mismatches++;
    end
    $display("run covered %0d bytes over %0d delimiter/type settings", bytes_in, NUM_PHASES);
    $display("%0d frames passed, %0d frames ended in error, %0d payload beats",
             frames_ok, frame_errors, payload_beats);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/afrp_pkg.sv
sv/api_frame_receive_parser_core.sv
tb/sv/api_frame_receive_parser_core_test.sv
